// ===== hw/rtl/lwb_pkg.sv =====
package lwb_pkg;

  typedef struct packed {
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0] ring_position;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] white_out;
    logic       last_led;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } colour_t;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PERIOD = 3'd0,
    CFG_RED    = 3'd1,
    CFG_GREEN  = 3'd2,
    CFG_BLUE   = 3'd3,
    CFG_WHITE  = 3'd4
  } cfg_index_t;

  localparam logic [15:0] PERIOD_RESET = 16'd2000;
  localparam logic [7:0]  RED_RESET    = 8'd255;
  localparam logic [7:0]  GREEN_RESET  = 8'd255;
  localparam logic [7:0]  BLUE_RESET   = 8'd255;
  localparam logic [7:0]  WHITE_RESET  = 8'd0;

  // phase divider: {time_ms, 16'b0} / period, low 16 quotient bits are the phase
  localparam int DIVIDEND_W = 48;
  localparam int DIV_STEP   = 6;
  localparam int DIV_CYCLES = DIVIDEND_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // wave centre in signed Q16
  localparam int WAVE_W = 20;
  localparam logic [17:0] EASE_THREE = 18'd196608;
  localparam logic [16:0] WAVE_SPAN  = 17'd104858;
  localparam logic signed [WAVE_W-1:0] WAVE_START = -20'sd19661;

  localparam int POS_W  = 18;
  localparam int DIST_W = 21;
  localparam int MAG_W  = DIST_W - 1;
  localparam logic [MAG_W-1:0] HALF_WIDTH = 20'd32768;

  localparam int QUEUE_DEPTH = 2;

  // squared raised cosine entry, x in Q16 over 0 .. 1 of the half width
  function automatic logic [7:0] profile_entry(input longint x);
    longint y;
    longint a;
    longint b;
    longint c1;
    longint c;
    longint c2;
    longint b16;
    longint v;
    y  = (x * x) / 65536;
    a  = 1367 - (y * 60) / 65536;
    b  = 16624 - (y * a) / 65536;
    c1 = 80852 - (y * b) / 65536;
    c  = 65536 - (y * c1) / 65536;
    if (c < 0) c = 0;
    if (c > 65536) c = 65536;
    c2  = (c * c) / 65536;
    b16 = (c2 * c2) / 65536;
    v   = (b16 * 255) / 65536;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // level * br / 255, truncated; exact for 16-bit products
  function automatic logic [7:0] scale_level(input logic [7:0] level, input logic [7:0] br);
    logic [16:0] p;
    logic [16:0] q;
    p = 17'(level) * 17'(br);
    q = p + 17'd1;
    q = q + (q >> 8);
    return q[15:8];
  endfunction

endpackage

// ===== hw/rtl/lwb_stream_if.sv =====
interface lwb_stream_if #(parameter type T = logic [0:0]) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lwb_front.sv =====
module lwb_front (
  input  logic                                clk,
  input  logic                                rst,
  lwb_stream_if.sink                          time_in,
  input  logic [15:0]                         anim_period,
  output logic                                wave_valid,
  input  logic                                wave_ready,
  output logic signed [lwb_pkg::WAVE_W-1:0]   wave_centre
);

  lwb_pkg::div_state_t state, state_next;

  logic [lwb_pkg::DIV_CNT_W-1:0]  cnt;
  logic [lwb_pkg::DIVIDEND_W-1:0] dvd;
  logic [15:0]                    divisor;
  logic [15:0]                    rem;
  logic [15:0]                    rem_next;
  logic [15:0]                    quo;
  logic [lwb_pkg::DIV_STEP-1:0]   qbits;
  logic                           accept;
  logic                           handoff;
  logic                           sh_en;

  logic                           s1_valid;
  logic                           s2_valid;
  logic                           s3_valid;
  logic [15:0]                    s1_t2;
  logic [17:0]                    s1_m;
  logic [17:0]                    s2_e;
  logic signed [lwb_pkg::WAVE_W-1:0] s3_w;
  logic [31:0]                    sq;
  logic [33:0]                    ease_prod;
  logic [34:0]                    span_prod;

  // several restoring steps per cycle
  always_comb begin
    logic [16:0] trial;
    rem_next = rem;
    qbits    = '0;
    for (int s = 0; s < lwb_pkg::DIV_STEP; s++) begin
      trial = {rem_next, dvd[lwb_pkg::DIVIDEND_W-1-s]};
      if (trial >= {1'b0, divisor}) begin
        rem_next = 16'(trial - {1'b0, divisor});
        qbits[lwb_pkg::DIV_STEP-1-s] = 1'b1;
      end else begin
        rem_next = trial[15:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lwb_pkg::DIV_IDLE: begin
        if (accept) state_next = lwb_pkg::DIV_RUN;
      end
      lwb_pkg::DIV_RUN: begin
        if (cnt == lwb_pkg::DIV_CNT_W'(lwb_pkg::DIV_CYCLES - 1))
          state_next = lwb_pkg::DIV_DONE;
      end
      lwb_pkg::DIV_DONE: begin
        if (accept) state_next = lwb_pkg::DIV_RUN;
        else if (handoff) state_next = lwb_pkg::DIV_IDLE;
      end
      default: state_next = lwb_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    time_in.ready = 1'b0;
    handoff       = 1'b0;
    unique case (state)
      lwb_pkg::DIV_IDLE: time_in.ready = 1'b1;
      lwb_pkg::DIV_DONE: begin
        handoff       = sh_en;
        time_in.ready = sh_en;
      end
      default: ;
    endcase
  end

  assign accept = time_in.valid && time_in.ready;
  assign sh_en  = !s3_valid || wave_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwb_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dvd     <= {time_in.data.time_ms, 16'd0};
      rem     <= '0;
      cnt     <= '0;
      divisor <= (anim_period == 16'd0) ? 16'd1 : anim_period;
    end else if (state == lwb_pkg::DIV_RUN) begin
      dvd <= dvd << lwb_pkg::DIV_STEP;
      rem <= rem_next;
      quo <= {quo[15-lwb_pkg::DIV_STEP:0], qbits};
      cnt <= cnt + 1'b1;
    end
  end

  // smoothstep and centre mapping, one multiply per stage
  assign sq        = 32'(quo) * 32'(quo);
  assign ease_prod = 34'(s1_t2) * 34'(s1_m);
  assign span_prod = 35'(s2_e) * 35'(lwb_pkg::WAVE_SPAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (sh_en) begin
      s1_valid <= (state == lwb_pkg::DIV_DONE);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sh_en) begin
      s1_t2 <= sq[31:16];
      s1_m  <= lwb_pkg::EASE_THREE - {1'b0, quo, 1'b0};
      s2_e  <= ease_prod[33:16];
      s3_w  <= lwb_pkg::WAVE_START + $signed({1'b0, span_prod[34:16]});
    end
  end

  assign wave_valid  = s3_valid;
  assign wave_centre = s3_w;

endmodule

// ===== hw/rtl/lwb_fifo.sv =====
module lwb_fifo #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== hw/rtl/lwb_back.sv =====
module lwb_back #(
  parameter int RING_LEDS           = 10,
  parameter int PROFILE_TABLE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wave_valid,
  output logic                               wave_ready,
  input  logic signed [lwb_pkg::WAVE_W-1:0]  wave_centre,
  input  lwb_pkg::colour_t                   levels,
  lwb_stream_if.source                       led_out
);

  localparam int IDX_W    = $clog2(RING_LEDS);
  localparam int HALF     = RING_LEDS / 2;
  localparam int STEP_DIV = (HALF > 1) ? HALF - 1 : 1;
  localparam int KW       = $clog2(PROFILE_TABLE_DEPTH);
  localparam int SCALE_W  = 15 + $clog2(PROFILE_TABLE_DEPTH + 1);

  logic signed [lwb_pkg::POS_W-1:0] pos_tab [RING_LEDS];
  logic [7:0]                       rom [PROFILE_TABLE_DEPTH];

  for (genvar g = 0; g < RING_LEDS; g++) begin : g_pos
    localparam int P = (g < HALF) ? (g * 65536) / STEP_DIV
                                  : 65536 - ((g - HALF) * 65536) / STEP_DIV;
    assign pos_tab[g] = lwb_pkg::POS_W'(P);
  end

  for (genvar g = 0; g < PROFILE_TABLE_DEPTH; g++) begin : g_rom
    localparam longint X = (longint'(g) * 65536) / PROFILE_TABLE_DEPTH;
    assign rom[g] = lwb_pkg::profile_entry(X);
  end

  logic                               cur_valid;
  logic signed [lwb_pkg::WAVE_W-1:0]  cur_w;
  logic [IDX_W-1:0]                   idx;
  logic                               a_valid;
  logic [IDX_W-1:0]                   a_idx;
  logic                               a_last;
  logic [7:0]                         a_br;
  logic                               o_valid;
  lwb_pkg::out_item_t                 o_data;

  logic signed [lwb_pkg::DIST_W-1:0]  delta;
  logic [lwb_pkg::MAG_W-1:0]          mag;
  logic [SCALE_W-1:0]                 scaled;
  logic [KW-1:0]                      k;
  logic [7:0]                         br;
  logic                               o_free;
  logic                               a_free;
  logic                               step;
  logic                               last_idx;
  logic                               load_cur;

  // distance from the wave centre, folded to a profile index
  assign delta  = lwb_pkg::DIST_W'(pos_tab[idx]) - lwb_pkg::DIST_W'(cur_w);
  assign mag    = delta[lwb_pkg::DIST_W-1] ? lwb_pkg::MAG_W'(-delta)
                                           : delta[lwb_pkg::MAG_W-1:0];
  assign scaled = SCALE_W'(mag[14:0]) * SCALE_W'(PROFILE_TABLE_DEPTH);
  assign k      = scaled[15 +: KW];
  assign br     = (mag < lwb_pkg::HALF_WIDTH) ? rom[k] : 8'd0;

  assign o_free     = !o_valid || led_out.ready;
  assign a_free     = !a_valid || o_free;
  assign step       = cur_valid && a_free;
  assign last_idx   = (idx == IDX_W'(RING_LEDS - 1));
  assign wave_ready = !cur_valid || (step && last_idx);
  assign load_cur   = wave_valid && wave_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      a_valid   <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      if (load_cur) cur_valid <= 1'b1;
      else if (step && last_idx) cur_valid <= 1'b0;
      if (step) idx <= last_idx ? '0 : idx + 1'b1;
      if (a_free) a_valid <= step;
      if (o_free) o_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) cur_w <= wave_centre;
    if (step) begin
      a_idx  <= idx;
      a_last <= last_idx;
      a_br   <= br;
    end
    if (o_free && a_valid) begin
      o_data.ring_position <= 4'(a_idx);
      o_data.red_out       <= lwb_pkg::scale_level(levels.red, a_br);
      o_data.green_out     <= lwb_pkg::scale_level(levels.green, a_br);
      o_data.blue_out      <= lwb_pkg::scale_level(levels.blue, a_br);
      o_data.white_out     <= lwb_pkg::scale_level(levels.white, a_br);
      o_data.last_led      <= a_last;
    end
  end

  assign led_out.valid = o_valid;
  assign led_out.data  = o_data;

endmodule

// ===== hw/rtl/led_wave_brightness.sv =====
// Channel    Dir  Handshake     Payload
// time_in    in   valid/ready   time_ms
// led_out    out  valid/ready   ring_position, red/green/blue/white_out, last_led
// cfg        in   cfg_we        cfg_index, cfg_data
//
// One timestamp gives RING_LEDS items. The divider takes the next timestamp in the
// cycle that it hands its result on. The phase divider retires 6 quotient bits a
// cycle, the LED sequencer emits one item per cycle while a centre waits and
// led_out does not stall. Items pass the divider, shaping stages, centre queue and
// output registers. Synchronous reset clears control and loads register defaults. A
// two-entry queue of wave centres lets the divider run on while led_out is stalled.
module led_wave_brightness #(
  parameter int RING_LEDS           = 10,
  parameter int PROFILE_TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  lwb_stream_if.sink                       time_in,
  lwb_stream_if.source                     led_out,
  input  logic                             cfg_we,
  input  logic [lwb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lwb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [15:0]                       anim_period;
  lwb_pkg::colour_t                  levels;

  logic                              wave_valid;
  logic                              wave_ready;
  logic signed [lwb_pkg::WAVE_W-1:0] wave_centre;
  logic                              q_valid;
  logic                              q_ready;
  logic [lwb_pkg::WAVE_W-1:0]        q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      anim_period  <= lwb_pkg::PERIOD_RESET;
      levels.red   <= lwb_pkg::RED_RESET;
      levels.green <= lwb_pkg::GREEN_RESET;
      levels.blue  <= lwb_pkg::BLUE_RESET;
      levels.white <= lwb_pkg::WHITE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lwb_pkg::CFG_PERIOD: anim_period  <= cfg_data;
        lwb_pkg::CFG_RED:    levels.red   <= cfg_data[7:0];
        lwb_pkg::CFG_GREEN:  levels.green <= cfg_data[7:0];
        lwb_pkg::CFG_BLUE:   levels.blue  <= cfg_data[7:0];
        lwb_pkg::CFG_WHITE:  levels.white <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  lwb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .time_in     (time_in),
    .anim_period (anim_period),
    .wave_valid  (wave_valid),
    .wave_ready  (wave_ready),
    .wave_centre (wave_centre)
  );

  lwb_fifo #(
    .WIDTH (lwb_pkg::WAVE_W),
    .DEPTH (lwb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (wave_valid),
    .push_ready (wave_ready),
    .push_data  (wave_centre),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  lwb_back #(
    .RING_LEDS           (RING_LEDS),
    .PROFILE_TABLE_DEPTH (PROFILE_TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .wave_valid  (q_valid),
    .wave_ready  (q_ready),
    .wave_centre ($signed(q_data)),
    .levels      (levels),
    .led_out     (led_out)
  );

  // last item of a timestamp carries the top ring position
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    led_out.valid && led_out.data.last_led |->
      led_out.data.ring_position == 4'(RING_LEDS - 1))
    else $error("last_led on wrong ring position");

  // divider is busy for the cycle after it takes a timestamp
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    time_in.valid && time_in.ready |=> !time_in.ready)
    else $error("timestamp taken while divider busy");

  // shaping pipeline holds its centre while the queue is full
  a_wave_hold: assert property (@(posedge clk) disable iff (rst)
    wave_valid && !wave_ready |=> wave_valid && $stable(wave_centre))
    else $error("wave centre lost under back pressure");

endmodule

// ===== dv/lwb_wave_checker.sv =====
`timescale 1ns / 1ps

module lwb_wave_checker #(
  parameter int RING_LEDS           = 10,
  parameter int PROFILE_TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  lwb_stream_if                           time_in,
  lwb_stream_if                           led_out,
  input  logic                            cfg_we,
  input  logic [lwb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lwb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              outstanding
);

  logic [15:0]        period_reg;
  lwb_pkg::colour_t   wave_colour;
  lwb_pkg::out_item_t led_expect_q[$];

  // squared raised cosine, Q0.8, for profile index k
  function automatic longint raised_cos_sq(input longint k);
    longint x;
    longint sq;
    longint h3;
    longint h2;
    longint h1;
    longint cosv;
    longint cos2;
    longint cos4;
    longint lvl;
    x    = (k * 65536) / PROFILE_TABLE_DEPTH;
    sq   = (x * x) / 65536;
    h3   = 1367 - (sq * 60) / 65536;
    h2   = 16624 - (sq * h3) / 65536;
    h1   = 80852 - (sq * h2) / 65536;
    cosv = 65536 - (sq * h1) / 65536;
    if (cosv < 0) cosv = 0;
    if (cosv > 65536) cosv = 65536;
    cos2 = (cosv * cosv) / 65536;
    cos4 = (cos2 * cos2) / 65536;
    lvl  = (cos4 * 255) / 65536;
    if (lvl > 255) lvl = 255;
    return lvl;
  endfunction

  // right column climbs, left column runs back down
  function automatic longint ring_pos(input int i);
    longint half;
    longint step;
    half = RING_LEDS / 2;
    step = (half > 1) ? half - 1 : 1;
    if (i < half) return (longint'(i) * 65536) / step;
    return 65536 - ((longint'(i) - half) * 65536) / step;
  endfunction

  function automatic longint wave_centre(input logic [31:0] tm);
    longint per;
    longint phase;
    longint phase_sq;
    longint eased;
    per      = (period_reg == 16'd0) ? 1 : longint'(period_reg);
    phase    = ((longint'(tm) % per) * 65536) / per;
    phase_sq = (phase * phase) / 65536;
    eased    = (phase_sq * (196608 - 2 * phase)) / 65536;
    return -19661 + (eased * 104858) / 65536;
  endfunction

  task automatic predict_leds(input logic [31:0] tm);
    longint             centre;
    longint             delta;
    longint             bright;
    lwb_pkg::out_item_t led;
    centre = wave_centre(tm);
    for (int i = 0; i < RING_LEDS; i++) begin
      delta = ring_pos(i) - centre;
      if (delta < 0) delta = -delta;
      bright = 0;
      if (delta < 32768) bright = raised_cos_sq((2 * delta * PROFILE_TABLE_DEPTH) >>> 16);
      led.ring_position = 4'(i);
      led.red_out       = 8'((longint'(wave_colour.red) * bright) / 255);
      led.green_out     = 8'((longint'(wave_colour.green) * bright) / 255);
      led.blue_out      = 8'((longint'(wave_colour.blue) * bright) / 255);
      led.white_out     = 8'((longint'(wave_colour.white) * bright) / 255);
      led.last_led      = (i == RING_LEDS - 1);
      led_expect_q.push_back(led);
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    lwb_pkg::out_item_t want;
    lwb_pkg::out_item_t got;
    if (rst) begin
      period_reg        <= lwb_pkg::PERIOD_RESET;
      wave_colour.red   <= lwb_pkg::RED_RESET;
      wave_colour.green <= lwb_pkg::GREEN_RESET;
      wave_colour.blue  <= lwb_pkg::BLUE_RESET;
      wave_colour.white <= lwb_pkg::WHITE_RESET;
      led_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lwb_pkg::CFG_PERIOD: period_reg <= cfg_data;
          lwb_pkg::CFG_RED:    wave_colour.red <= cfg_data[7:0];
          lwb_pkg::CFG_GREEN:  wave_colour.green <= cfg_data[7:0];
          lwb_pkg::CFG_BLUE:   wave_colour.blue <= cfg_data[7:0];
          lwb_pkg::CFG_WHITE:  wave_colour.white <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (time_in.valid && time_in.ready) predict_leds(time_in.data.time_ms);
      if (led_out.valid && led_out.ready) begin
        got = led_out.data;
        if (led_expect_q.size() == 0) begin
          $error("LED item for ring position %0d with nothing expected", got.ring_position);
          mismatches++;
        end else begin
          want = led_expect_q.pop_front();
          check_field("ring_position", int'(want.ring_position), int'(got.ring_position));
          check_field("red_out", int'(want.red_out), int'(got.red_out));
          check_field("green_out", int'(want.green_out), int'(got.green_out));
          check_field("blue_out", int'(want.blue_out), int'(got.blue_out));
          check_field("white_out", int'(want.white_out), int'(got.white_out));
          check_field("last_led", int'(want.last_led), int'(got.last_led));
        end
      end
    end
    outstanding <= led_expect_q.size();
  end

endmodule

// ===== dv/tb_led_wave_brightness.sv =====
`timescale 1ns / 1ps

module tb_led_wave_brightness;

  localparam int RING_LEDS           = 10;
  localparam int PROFILE_TABLE_DEPTH = 256;
  localparam int WATCHDOG_LIMIT      = 4000;
  localparam int HOLD_OFF_CYCLES     = 400;
  localparam int TAIL_CYCLES         = 40;
  localparam int ITEMS_PER_SETTING   = 35;
  localparam logic [lwb_pkg::CFG_INDEX_W-1:0] CFG_FIRST_UNUSED =
    lwb_pkg::CFG_INDEX_W'(lwb_pkg::CFG_WHITE + 1);

  logic clk = 1'b0;
  logic rst = 1'b1;

  lwb_stream_if #(.T(lwb_pkg::in_item_t))  time_if ();
  lwb_stream_if #(.T(lwb_pkg::out_item_t)) led_if ();

  logic                            cfg_we    = 1'b0;
  logic [lwb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lwb_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  bit          hold_ack       = 1'b0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;
  int          mismatches;
  int          outstanding;
  logic [15:0] cur_period     = lwb_pkg::PERIOD_RESET;

  always #10 clk = ~clk;

  led_wave_brightness #(
    .RING_LEDS           (RING_LEDS),
    .PROFILE_TABLE_DEPTH (PROFILE_TABLE_DEPTH)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .time_in   (time_if),
    .led_out   (led_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lwb_wave_checker #(
    .RING_LEDS           (RING_LEDS),
    .PROFILE_TABLE_DEPTH (PROFILE_TABLE_DEPTH)
  ) chk (
    .clk         (clk),
    .rst         (rst),
    .time_in     (time_if),
    .led_out     (led_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // LED sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      led_if.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_OFF_CYCLES;
      led_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      led_if.ready <= 1'b0;
    end else begin
      led_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (time_if.valid && time_if.ready) || (led_if.valid && led_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("led_wave_brightness regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays up from one item to the next unless an idle cycle is drawn
  task automatic send_time(input logic [31:0] tm);
    while ($urandom_range(99) < send_idle_pct) begin
      time_if.valid <= 1'b0;
      @(posedge clk);
    end
    time_if.valid        <= 1'b1;
    time_if.data.time_ms <= tm;
    @(posedge clk);
    while (!time_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    time_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lwb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lwb_pkg::CFG_DATA_W-1:0]  val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // colour writes carry random upper bits, which the block must drop
  task automatic set_wave(input logic [15:0] per, input logic [7:0] r, input logic [7:0] g,
                          input logic [7:0] b, input logic [7:0] w);
    write_reg(lwb_pkg::CFG_PERIOD, per);
    write_reg(lwb_pkg::CFG_RED, {8'($urandom), r});
    write_reg(lwb_pkg::CFG_GREEN, {8'($urandom), g});
    write_reg(lwb_pkg::CFG_BLUE, {8'($urandom), b});
    write_reg(lwb_pkg::CFG_WHITE, {8'($urandom), w});
    cfg_we <= 1'b0;
    cur_period = per;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'd65535;
      2:       return 16'($urandom_range(64, 1));
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    logic [31:0] per;
    per = (cur_period == 16'd0) ? 32'd1 : 32'(cur_period);
    case ($urandom_range(3))
      0:       return $urandom_range(3 * per);
      // right around a period boundary
      1:       return per * $urandom_range(65535) + $urandom_range(2) - 1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    time_if.valid <= 1'b0;
    time_if.data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: phase start, middle, wrap and the extremes of time
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'd999);
    send_time(32'd1000);
    send_time(32'd1999);
    send_time(32'd2000);
    send_time(32'hFFFF_FFFF);

    drain();
    set_wave(16'd65535, 8'd255, 8'd0, 8'd128, 8'd255);
    send_time(32'd65534);
    send_time(32'd32767);
    send_time(32'hFFFF_FFFF);
    send_time(32'h8000_0000);

    drain();
    set_wave(16'd1, 8'd10, 8'd20, 8'd30, 8'd40);
    send_time(32'd12345);

    // zero period behaves as one
    drain();
    set_wave(16'd0, 8'd200, 8'd100, 8'd50, 8'd25);
    send_time(32'd7);
    send_time(32'hFFFF_FFFF);

    drain();
    set_wave(16'd1000, 8'd0, 8'd0, 8'd0, 8'd0);
    send_time(32'd500);

    // writes to unused indexes must leave every register alone
    drain();
    set_wave(16'd1000, 8'd255, 8'd255, 8'd255, 8'd255);
    for (int k = int'(CFG_FIRST_UNUSED); k < (1 << lwb_pkg::CFG_INDEX_W); k++) begin
      write_reg(lwb_pkg::CFG_INDEX_W'(k), 16'd0);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    send_time(32'd450);
    send_time(32'd500);
    send_time(32'd550);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 50; end
        default: begin send_idle_pct = 38; recv_stall_pct <= 38; end
      endcase
      for (int setting = 0; setting < 2; setting++) begin
        drain();
        set_wave(pick_period(), pick_level(), pick_level(), pick_level(), pick_level());
        // back the block up against a stopped sink
        if (phase == 0 && setting == 0) hold_req <= ~hold_req;
        for (int n = 0; n < ITEMS_PER_SETTING; n++) send_time(pick_time());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("led_wave_brightness regression: pass");
    end else begin
      $display("led_wave_brightness regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lwb_pkg.sv
hw/rtl/lwb_stream_if.sv
hw/rtl/lwb_front.sv
hw/rtl/lwb_fifo.sv
hw/rtl/lwb_back.sv
hw/rtl/led_wave_brightness.sv
dv/lwb_wave_checker.sv
dv/tb_led_wave_brightness.sv
